>>> rtl/sorted_priority_queue_assert.svh
// ----------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Shared concurrent assertion forms, clocked on i_clk and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define SPQ_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Widths, request and status codes, and the entry types shared by the block.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int SPQ_CAPACITY = 16;
    localparam int DATA_W       = 32;
    localparam int OCC_W        = 5;
    localparam int STAT_W       = 2;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_POP_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_PUSH_FULL = 2'd2;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [DATA_W-1:0] prio;
    } t_entry;

    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctrl;

endpackage

>>> rtl/spq_if.sv
// ----------------------------------------------------------------------------
// Sorted priority queue channel interfaces
// Request channel and result channel, each with valid/ready and payload.
// ----------------------------------------------------------------------------
interface spq_in_if;
    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic signed [31:0]       data_value;
    logic signed [31:0]       priority_req;

    modport source (output valid, req_type, data_value, priority_req, input ready);
    modport sink   (input valid, req_type, data_value, priority_req, output ready);
endinterface

interface spq_out_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic signed [31:0]       popped_data;
    logic signed [31:0]       popped_priority;
    logic                     head_valid;
    logic signed [31:0]       head_data;
    logic signed [31:0]       head_priority;
    logic [4:0]               occupancy;

    modport source (output valid, status, popped_data, popped_priority, head_valid,
                    head_data, head_priority, occupancy, input ready);
    modport sink   (input valid, status, popped_data, popped_priority, head_valid,
                    head_data, head_priority, occupancy, output ready);
endinterface

>>> rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// One slot of the queue: compares against the pushed priority and either
// holds, takes the new entry, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
#(
    parameter bit IS_HEAD = 1'b0
) (
    input  logic       i_clk,
    input  t_cell_ctrl i_ctl,
    input  logic       i_valid,
    input  t_entry     i_new,
    input  t_entry     i_left,
    input  logic       i_left_keep,
    input  t_entry     i_right,
    output t_entry     o_entry,
    output t_entry     o_next,
    output logic       o_keep
);

    t_entry r_entry;
    t_entry n_entry;
    logic   w_ahead;

    // The head keeps its place on a tie; every other slot yields on a tie.
    always_comb begin
        if (IS_HEAD) begin
            w_ahead = $signed(r_entry.prio) >= $signed(i_new.prio);
        end else begin
            w_ahead = $signed(r_entry.prio) > $signed(i_new.prio);
        end
    end

    assign o_keep = i_valid && w_ahead;

    always_comb begin
        priority if (i_ctl.push) begin
            priority if (o_keep) begin
                n_entry = r_entry;
            end else if (IS_HEAD || i_left_keep) begin
                n_entry = i_new;
            end else begin
                n_entry = i_left;
            end
        end else if (i_ctl.pop) begin
            n_entry = i_right;
        end else begin
            n_entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_next  = n_entry;

endmodule

>>> rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// Sorted priority queue
// Bounded queue kept in descending priority order in a row of compare cells.
// ----------------------------------------------------------------------------
// The block takes one request per clock when ready: a push or a pop of the
// head. Every request produces exactly one result transfer, offered in the
// following cycle, carrying the status, the popped entry, the new head and
// the occupancy. Entries live in a row of CAPACITY cells; on a push every
// cell compares its priority with the new one in parallel and either holds,
// takes the new entry, or takes the entry of its left neighbor, all at once
// wherever it lands. A pop moves every entry one cell toward the head. A new
// priority that beats the head goes first; otherwise it lands behind every
// strictly higher entry, and directly behind the head when it ties with the
// head. A push to a full queue is dropped with status 2, a pop from an empty
// queue reports status 1. Results sit in an output register, so a new request
// is taken while the previous result waits, as long as the result channel
// drains it in the same cycle; the sustained rate is one item per cycle. Slot
// contents need no clearing: only occupied cells are compared.
// ----------------------------------------------------------------------------
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY = SPQ_CAPACITY
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    spq_in_if.sink       i_in,
    spq_out_if.source    o_out
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Occupancy count; cell i holds an entry when i is below it.
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // Output register for the result transfer.
    logic              r_out_valid;
    logic [STAT_W-1:0] r_status;
    t_entry            r_popped;
    logic              r_head_valid;
    t_entry            r_head;
    logic [OCC_W-1:0]  r_occupancy;

    logic        w_accept;
    logic        w_is_push;
    logic        w_full;
    logic        w_empty;
    t_cell_ctrl  w_ctl;
    t_entry      w_new;

    t_entry      w_entry [CAPACITY];
    t_entry      w_next  [CAPACITY];
    logic        w_keep  [CAPACITY];

    // A request transfer happens whenever the result register is free or
    // is being drained in the same cycle.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_is_push  = (i_in.req_type == REQ_PUSH);
    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_empty    = (r_count == '0);

    assign w_new.data = i_in.data_value;
    assign w_new.prio = i_in.priority_req;

    // A dropped push or an empty pop leaves the cells untouched.
    assign w_ctl.push = w_accept && w_is_push && !w_full;
    assign w_ctl.pop  = w_accept && !w_is_push && !w_empty;

    always_comb begin
        priority if (w_ctl.push) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctl.pop) begin
            n_count = r_count - CNT_W'(1);
        end else begin
            n_count = r_count;
        end
    end

    // The row of cells. The head sees the new entry as its left neighbor;
    // the tail sees itself on the right, which only matters for a slot that
    // becomes empty.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_entry w_left;
        logic   w_left_keep;
        t_entry w_right;

        if (g == 0) begin : g_head
            assign w_left      = w_new;
            assign w_left_keep = 1'b0;
        end else begin : g_body
            assign w_left      = w_entry[g-1];
            assign w_left_keep = w_keep[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right = w_entry[g];
        end else begin : g_inner
            assign w_right = w_entry[g+1];
        end

        spq_cell #(
            .IS_HEAD (g == 0)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_valid     (CNT_W'(g) < r_count),
            .i_new       (w_new),
            .i_left      (w_left),
            .i_left_keep (w_left_keep),
            .i_right     (w_right),
            .o_entry     (w_entry[g]),
            .o_next      (w_next[g]),
            .o_keep      (w_keep[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload, captured with the request; the head is taken from the
    // cell's next value so it matches the state after this request.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            priority if (w_is_push && w_full) begin
                r_status <= ST_PUSH_FULL;
            end else if (!w_is_push && w_empty) begin
                r_status <= ST_POP_EMPTY;
            end else begin
                r_status <= ST_OK;
            end
            r_popped     <= w_ctl.pop ? w_entry[0] : '0;
            r_head_valid <= (n_count != '0);
            r_head       <= (n_count != '0) ? w_next[0] : '0;
            r_occupancy  <= OCC_W'(n_count);
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.status          = r_status;
    assign o_out.popped_data     = r_popped.data;
    assign o_out.popped_priority = r_popped.prio;
    assign o_out.head_valid      = r_head_valid;
    assign o_out.head_data       = r_head.data;
    assign o_out.head_priority   = r_head.prio;
    assign o_out.occupancy       = r_occupancy;

endmodule

>>> rtl/spq_checker.sv
// ----------------------------------------------------------------------------
// Sorted priority queue checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_assert.svh"

module spq_checker
    import spq_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [STAT_W-1:0] i_status,
    input logic [31:0]       i_popped_data,
    input logic [31:0]       i_popped_priority,
    input logic              i_head_valid,
    input logic [OCC_W-1:0]  i_occupancy
);

    logic w_out_stall;
    logic w_occupied;
    logic w_push_full;
    logic w_pop_empty;
    logic w_empty_clean;

    assign w_out_stall   = i_out_valid && !i_out_ready;
    assign w_occupied    = i_out_valid && (i_occupancy != '0);
    assign w_push_full   = i_out_valid && (i_status == ST_PUSH_FULL);
    assign w_pop_empty   = i_out_valid && (i_status == ST_POP_EMPTY);
    assign w_empty_clean = !i_head_valid && (i_popped_data == '0) && (i_popped_priority == '0);

    // A result that is not taken stays offered.
    `SPQ_ASSERT_NEXT(a_out_hold, w_out_stall, i_out_valid, "result dropped while stalled")

    // A reported occupancy means there is a head.
    `SPQ_ASSERT_IMPLY(a_head_occ, w_occupied, i_head_valid, "occupancy without head")

    // A dropped push can only happen on a non-empty queue.
    `SPQ_ASSERT_IMPLY(a_full_head, w_push_full, i_head_valid, "full queue without head")

    // A failed pop removes nothing and leaves an empty queue.
    `SPQ_ASSERT_IMPLY(a_empty_pop, w_pop_empty, w_empty_clean, "empty pop reported an entry")

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_status          (o_out.status),
    .i_popped_data     (o_out.popped_data),
    .i_popped_priority (o_out.popped_priority),
    .i_head_valid      (o_out.head_valid),
    .i_occupancy       (o_out.occupancy)
);
